/* design/gsa_pkg.sv */
`timescale 1ns / 1ps
package gsa_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int VER_W      = 12;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int PTR_W      = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W      = PTR_W;
  localparam int CUR_W      = PTR_W + 1;
  localparam int RL_DEPTH   = SLOT_COUNT + 1;

  localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(SLOT_COUNT);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ALIVE   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

endpackage

/* design/gsa_ram.sv */
`timescale 1ns / 1ps
module gsa_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/generational_slot_allocator_unit.sv */
`timescale 1ns / 1ps
// Generational slot allocator: hands out handles made of a slot index and a
// 12-bit version, frees them, checks them and clears all of them.
// Command channel: drive opcode and the handle fields with start high; the
// word is taken at a rising edge where start is high and busy is low. busy
// stays high until the result has been produced.
// Result channel: result_valid is high for exactly one cycle with status,
// new_index, new_version, is_alive, live_total and dead_total. The receiver
// cannot stall; it must take the word in that cycle.
// Sequence: create, destroy and alive check make three reads of the skip store
// through its one read port and take the last word, then run three write
// phases before the result strobe. A clear walks over the live slots, one
// read-read-write pass each; a clear with nothing live gives its result
// without a walk. A new command may be accepted in the cycle that shows the
// result.
// Reset: the free-run list is empty and all counters are zero. The slot
// stores need no clearing pass; entries are written before they are read.
module generational_slot_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [gsa_pkg::OP_W-1:0]      opcode,
  input  logic [gsa_pkg::IDX_W-1:0]     handle_index,
  input  logic [gsa_pkg::VER_W-1:0]     handle_version,
  input  logic                          handle_null,
  output logic                          result_valid,
  output logic [gsa_pkg::STATUS_W-1:0]  status,
  output logic [gsa_pkg::IDX_W-1:0]     new_index,
  output logic [gsa_pkg::VER_W-1:0]     new_version,
  output logic                          is_alive,
  output logic [gsa_pkg::CNT_W-1:0]     live_total,
  output logic [gsa_pkg::CNT_W-1:0]     dead_total
);

  import gsa_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_RD0      = 15'b000000000000010,
    S_RD1      = 15'b000000000000100,
    S_RD2      = 15'b000000000001000,
    S_RD3      = 15'b000000000010000,
    S_WR0      = 15'b000000000100000,
    S_WR1      = 15'b000000001000000,
    S_WR2      = 15'b000000010000000,
    S_CLR0     = 15'b000000100000000,
    S_CLR_INIT = 15'b000001000000000,
    S_CLR_CHK  = 15'b000010000000000,
    S_CLR_RDN  = 15'b000100000000000,
    S_CLR_UPD  = 15'b001000000000000,
    S_CLR_END0 = 15'b010000000000000,
    S_CLR_END1 = 15'b100000000000000
  } state_t;

  state_t state;

  // command word
  op_t              op_q;
  logic [IDX_W-1:0] hidx_q;
  logic [VER_W-1:0] hver_q;
  logic             hnull_q;

  // captured store words
  logic [PTR_W-1:0] rl_a, rl_b, rl_c, nx_q, pv_q;
  logic [VER_W-1:0] ver_q;
  logic [CUR_W-1:0] cursor;

  // scalar state
  logic [PTR_W-1:0] list_head;
  logic [CNT_W-1:0] used_count, live_count, dead_count;

  // memory ports
  logic             rl_we, ver_we, nx_we, pv_we;
  logic [PTR_W-1:0] rl_wa, rl_ra, rl_wd, rl_rd;
  logic [IDX_W-1:0] ver_wa, ver_ra, nx_wa, nx_ra, pv_wa, pv_ra;
  logic [VER_W-1:0] ver_wd, ver_rd;
  logic [PTR_W-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

  // write plan, three phases
  logic [2:0]       rl_we_p, nx_we_p, pv_we_p;
  logic [PTR_W-1:0] rl_wa_p [3];
  logic [PTR_W-1:0] rl_wd_p [3];
  logic [IDX_W-1:0] nx_wa_p [3];
  logic [PTR_W-1:0] nx_wd_p [3];
  logic [IDX_W-1:0] pv_wa_p [3];
  logic [PTR_W-1:0] pv_wd_p [3];
  logic             ver_we_p;
  logic [IDX_W-1:0] ver_wa_p;
  logic [VER_W-1:0] ver_wd_p;
  logic [1:0]       ph;

  // step results
  status_t          res_status;
  logic [IDX_W-1:0] res_idx;
  logic [VER_W-1:0] res_ver;
  logic             res_alive;
  logic [PTR_W-1:0] head_n;
  logic [CNT_W-1:0] used_n, live_n, dead_n;

  // derived values
  logic             in_range, have_run, can_fresh, split, d_ok, left, right;
  logic [PTR_W-1:0] head_p1, tail, len_m1, hidx_w, hidx_p1, run_start, run_end;
  logic             clr_trivial, cursor_lt;

  assign busy = (state != S_IDLE);

  assign hidx_w      = PTR_W'(hidx_q);
  assign hidx_p1     = hidx_w + PTR_W'(1);
  assign in_range    = !hnull_q && (hidx_w < used_count);
  assign have_run    = (list_head != NO_SLOT);
  assign can_fresh   = (used_count < CNT_W'(SLOT_COUNT));
  assign head_p1     = list_head + PTR_W'(1);
  assign split       = (head_p1 < used_count) && (rl_a != '0);
  assign tail        = list_head + rl_b - PTR_W'(1);
  assign len_m1      = rl_b - PTR_W'(1);
  assign d_ok        = in_range && (rl_a == '0) && (ver_q == hver_q);
  assign left        = (hidx_q != '0) && (rl_b != '0);
  assign right       = (hidx_p1 < used_count) && (rl_c != '0);
  assign run_start   = hidx_w - rl_b;
  assign run_end     = hidx_w + rl_c;
  assign clr_trivial = (used_count == '0) || (live_count == '0);
  assign cursor_lt   = (cursor < CUR_W'(used_count));

  // issue read addresses
  always_comb begin
    rl_ra  = '0;
    ver_ra = (op_q == OP_CREATE) ? list_head[IDX_W-1:0] : hidx_q;
    nx_ra  = (op_q == OP_CREATE) ? list_head[IDX_W-1:0] : hidx_p1[IDX_W-1:0];
    pv_ra  = hidx_p1[IDX_W-1:0];
    unique case (state)
      S_RD0: begin
        if (op_q == OP_CREATE) begin
          rl_ra = have_run ? head_p1 : '0;
        end else begin
          rl_ra = hidx_w;
        end
      end
      S_RD1: begin
        if (op_q == OP_CREATE) begin
          rl_ra = have_run ? list_head : '0;
        end else begin
          rl_ra = (hidx_q != '0) ? hidx_w - PTR_W'(1) : '0;
        end
      end
      S_RD2: rl_ra = hidx_p1;
      S_CLR_CHK: begin
        rl_ra  = cursor[PTR_W-1:0];
        ver_ra = cursor[IDX_W-1:0];
      end
      S_CLR_RDN: begin
        rl_ra  = cursor[PTR_W-1:0] + PTR_W'(1);
        ver_ra = cursor[IDX_W-1:0];
      end
      default: rl_ra = '0;
    endcase
  end

  // plan the writes and the result of one command
  always_comb begin
    rl_we_p    = '0;
    nx_we_p    = '0;
    pv_we_p    = '0;
    rl_wa_p    = '{default: '0};
    rl_wd_p    = '{default: '0};
    nx_wa_p    = '{default: '0};
    nx_wd_p    = '{default: '0};
    pv_wa_p    = '{default: '0};
    pv_wd_p    = '{default: '0};
    ver_we_p   = 1'b0;
    ver_wa_p   = '0;
    ver_wd_p   = '0;
    res_status = ST_OK;
    res_idx    = '0;
    res_ver    = '0;
    res_alive  = 1'b0;
    head_n     = list_head;
    used_n     = used_count;
    live_n     = live_count;
    dead_n     = dead_count;
    case (op_q)
      OP_CREATE: begin
        if (have_run) begin
          // take the first slot of the head run
          res_idx = list_head[IDX_W-1:0];
          res_ver = ver_q;
          live_n  = live_count + CNT_W'(1);
          dead_n  = dead_count - CNT_W'(1);
          if (split) begin
            rl_we_p[0] = 1'b1;
            rl_wa_p[0] = tail;
            rl_wd_p[0] = len_m1;
            pv_we_p[0] = 1'b1;
            pv_wa_p[0] = head_p1[IDX_W-1:0];
            pv_wd_p[0] = NO_SLOT;
            nx_we_p[0] = 1'b1;
            nx_wa_p[0] = head_p1[IDX_W-1:0];
            nx_wd_p[0] = nx_q;
            rl_we_p[1] = 1'b1;
            rl_wa_p[1] = head_p1;
            rl_wd_p[1] = len_m1;
            pv_we_p[1] = (nx_q != NO_SLOT);
            pv_wa_p[1] = nx_q[IDX_W-1:0];
            pv_wd_p[1] = head_p1;
            head_n     = head_p1;
          end else begin
            pv_we_p[0] = (nx_q != NO_SLOT);
            pv_wa_p[0] = nx_q[IDX_W-1:0];
            pv_wd_p[0] = NO_SLOT;
            head_n     = nx_q;
          end
          rl_we_p[2] = 1'b1;
          rl_wa_p[2] = list_head;
          rl_wd_p[2] = '0;
        end else if (can_fresh) begin
          // open the next never-used slot
          res_idx    = used_count[IDX_W-1:0];
          ver_we_p   = 1'b1;
          ver_wa_p   = used_count[IDX_W-1:0];
          ver_wd_p   = '0;
          rl_we_p[0] = 1'b1;
          rl_wa_p[0] = used_count;
          rl_we_p[1] = 1'b1;
          rl_wa_p[1] = used_count + PTR_W'(1);
          used_n     = used_count + CNT_W'(1);
          live_n     = live_count + CNT_W'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (d_ok) begin
          ver_we_p = 1'b1;
          ver_wa_p = hidx_q;
          ver_wd_p = ver_q + VER_W'(1);
          live_n   = live_count - CNT_W'(1);
          dead_n   = dead_count + CNT_W'(1);
          if (!left && !right) begin
            // new run of one at the list head
            rl_we_p[0] = 1'b1;
            rl_wa_p[0] = hidx_w;
            rl_wd_p[0] = PTR_W'(1);
            nx_we_p[0] = 1'b1;
            nx_wa_p[0] = hidx_q;
            nx_wd_p[0] = list_head;
            pv_we_p[0] = 1'b1;
            pv_wa_p[0] = hidx_q;
            pv_wd_p[0] = NO_SLOT;
            pv_we_p[1] = have_run;
            pv_wa_p[1] = list_head[IDX_W-1:0];
            pv_wd_p[1] = hidx_w;
            head_n     = hidx_w;
          end else if (left && !right) begin
            // extend the run on the left
            rl_we_p[0] = 1'b1;
            rl_wa_p[0] = run_start;
            rl_wd_p[0] = rl_b + PTR_W'(1);
            rl_we_p[1] = 1'b1;
            rl_wa_p[1] = hidx_w;
            rl_wd_p[1] = rl_b + PTR_W'(1);
          end else if (!left) begin
            // slot becomes the start of the run on the right
            rl_we_p[0] = 1'b1;
            rl_wa_p[0] = hidx_w;
            rl_wd_p[0] = rl_c + PTR_W'(1);
            pv_we_p[0] = 1'b1;
            pv_wa_p[0] = hidx_q;
            pv_wd_p[0] = pv_q;
            nx_we_p[0] = 1'b1;
            nx_wa_p[0] = hidx_q;
            nx_wd_p[0] = nx_q;
            rl_we_p[1] = 1'b1;
            rl_wa_p[1] = run_end;
            rl_wd_p[1] = rl_c + PTR_W'(1);
            nx_we_p[1] = (pv_q != NO_SLOT);
            nx_wa_p[1] = pv_q[IDX_W-1:0];
            nx_wd_p[1] = hidx_w;
            pv_we_p[1] = (nx_q != NO_SLOT);
            pv_wa_p[1] = nx_q[IDX_W-1:0];
            pv_wd_p[1] = hidx_w;
            if (pv_q == NO_SLOT) begin
              head_n = hidx_w;
            end
          end else begin
            // join both runs, unlink the right one
            rl_we_p[0] = 1'b1;
            rl_wa_p[0] = hidx_w;
            rl_wd_p[0] = PTR_W'(1);
            nx_we_p[0] = (pv_q != NO_SLOT);
            nx_wa_p[0] = pv_q[IDX_W-1:0];
            nx_wd_p[0] = nx_q;
            pv_we_p[0] = (nx_q != NO_SLOT);
            pv_wa_p[0] = nx_q[IDX_W-1:0];
            pv_wd_p[0] = pv_q;
            if (pv_q == NO_SLOT) begin
              head_n = nx_q;
            end
            rl_we_p[1] = 1'b1;
            rl_wa_p[1] = run_start;
            rl_wd_p[1] = rl_b + rl_c + PTR_W'(1);
            rl_we_p[2] = 1'b1;
            rl_wa_p[2] = run_end;
            rl_wd_p[2] = rl_b + rl_c + PTR_W'(1);
          end
        end else begin
          res_status = ST_STALE;
        end
      end
      OP_ALIVE: begin
        if (in_range) begin
          res_alive = (rl_a == '0) && (ver_q == hver_q);
        end else begin
          res_status = ST_STALE;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  // select the write phase
  always_comb begin
    unique case (state)
      S_WR1:   ph = 2'd1;
      S_WR2:   ph = 2'd2;
      default: ph = 2'd0;
    endcase
  end

  // drive the write ports
  always_comb begin
    rl_we  = 1'b0;
    rl_wa  = '0;
    rl_wd  = '0;
    nx_we  = 1'b0;
    nx_wa  = '0;
    nx_wd  = '0;
    pv_we  = 1'b0;
    pv_wa  = '0;
    pv_wd  = '0;
    ver_we = 1'b0;
    ver_wa = '0;
    ver_wd = '0;
    unique case (state) inside
      S_WR0, S_WR1, S_WR2: begin
        rl_we  = rl_we_p[ph];
        rl_wa  = rl_wa_p[ph];
        rl_wd  = rl_wd_p[ph];
        nx_we  = nx_we_p[ph];
        nx_wa  = nx_wa_p[ph];
        nx_wd  = nx_wd_p[ph];
        pv_we  = pv_we_p[ph];
        pv_wa  = pv_wa_p[ph];
        pv_wd  = pv_wd_p[ph];
        ver_we = ver_we_p && (state == S_WR0);
        ver_wa = ver_wa_p;
        ver_wd = ver_wd_p;
      end
      S_CLR_UPD: begin
        rl_we  = 1'b1;
        rl_wa  = cursor[PTR_W-1:0];
        rl_wd  = PTR_W'(1);
        ver_we = (rl_a == '0);
        ver_wa = cursor[IDX_W-1:0];
        ver_wd = ver_q + VER_W'(1);
      end
      S_CLR_END0: begin
        rl_we = 1'b1;
        rl_wa = '0;
        rl_wd = used_count;
        nx_we = 1'b1;
        nx_wd = NO_SLOT;
        pv_we = 1'b1;
        pv_wd = NO_SLOT;
      end
      S_CLR_END1: begin
        rl_we = 1'b1;
        rl_wa = used_count - PTR_W'(1);
        rl_wd = used_count;
      end
      default: rl_we = 1'b0;
    endcase
  end

  // sequence one command
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      list_head    <= NO_SLOT;
      used_count   <= '0;
      live_count   <= '0;
      dead_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= op_t'(opcode);
            hidx_q  <= handle_index;
            hver_q  <= handle_version;
            hnull_q <= handle_null;
            state   <= (op_t'(opcode) == OP_CLEAR) ? S_CLR0 : S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          rl_a  <= rl_rd;
          ver_q <= ver_rd;
          nx_q  <= nx_rd;
          pv_q  <= pv_rd;
          state <= S_RD2;
        end
        S_RD2: begin
          rl_b  <= rl_rd;
          state <= S_RD3;
        end
        S_RD3: begin
          rl_c  <= rl_rd;
          state <= S_WR0;
        end
        S_WR0: state <= S_WR1;
        S_WR1: state <= S_WR2;
        S_WR2: begin
          list_head    <= head_n;
          used_count   <= used_n;
          live_count   <= live_n;
          dead_count   <= dead_n;
          status       <= res_status;
          new_index    <= res_idx;
          new_version  <= res_ver;
          is_alive     <= res_alive;
          live_total   <= live_n;
          dead_total   <= dead_n;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        S_CLR0: begin
          if (clr_trivial) begin
            status       <= ST_OK;
            new_index    <= '0;
            new_version  <= '0;
            is_alive     <= 1'b0;
            live_total   <= live_count;
            dead_total   <= dead_count;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_CLR_INIT;
          end
        end
        S_CLR_INIT: begin
          cursor <= CUR_W'(rl_rd);
          state  <= S_CLR_CHK;
        end
        S_CLR_CHK: state <= cursor_lt ? S_CLR_RDN : S_CLR_END0;
        S_CLR_RDN: begin
          rl_a  <= rl_rd;
          ver_q <= ver_rd;
          state <= S_CLR_UPD;
        end
        S_CLR_UPD: begin
          // hop over the free run that follows, if any
          cursor <= cursor + CUR_W'(rl_rd) + CUR_W'(1);
          state  <= S_CLR_CHK;
        end
        S_CLR_END0: state <= S_CLR_END1;
        S_CLR_END1: begin
          list_head    <= '0;
          live_count   <= '0;
          dead_count   <= used_count;
          status       <= ST_OK;
          new_index    <= '0;
          new_version  <= '0;
          is_alive     <= 1'b0;
          live_total   <= '0;
          dead_total   <= used_count;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gsa_ram #(.WIDTH(VER_W), .DEPTH(SLOT_COUNT)) u_ver_ram (
    .clk   (clk),
    .we    (ver_we),
    .waddr (ver_wa),
    .wdata (ver_wd),
    .raddr (ver_ra),
    .rdata (ver_rd)
  );

  gsa_ram #(.WIDTH(PTR_W), .DEPTH(RL_DEPTH)) u_rl_ram (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_wa),
    .wdata (rl_wd),
    .raddr (rl_ra),
    .rdata (rl_rd)
  );

  gsa_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_nx_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_wa),
    .wdata (nx_wd),
    .raddr (nx_ra),
    .rdata (nx_rd)
  );

  gsa_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_wa),
    .wdata (pv_wd),
    .raddr (pv_ra),
    .rdata (pv_rd)
  );

  // every used slot is either live or free
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (CUR_W'(live_count) + CUR_W'(dead_count)) == CUR_W'(used_count))
    else $error("live and free counts do not add up to used count");

  // free list is empty exactly when no used slot is free
  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (list_head == NO_SLOT) == (dead_count == '0))
    else $error("free list head disagrees with free count");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // full is reported only at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_FULL)) |-> (used_count == CNT_W'(SLOT_COUNT)))
    else $error("full reported below capacity");

endmodule
